/* rtl/core/bsds_pkg.sv */
// Shared types and constants for the byte stream delimiter splitter.
// Used by every module in rtl/core; it depends on nothing else.
package bsds_pkg;

    // Fixed field widths.
    localparam int BYTE_W     = 8;
    localparam int POS_OUT_W  = 17;
    localparam int DELIM_W    = 64;
    localparam int DLEN_W     = 4;
    localparam int CFG_IDX_W  = 4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_DELIM_BYTES  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DELIM_LENGTH = 4'd1;

    // Reset values of the configuration registers.
    localparam logic [DELIM_W-1:0] DELIM_BYTES_RST  = 64'd44;
    localparam logic [DLEN_W-1:0]  DELIM_LENGTH_RST = 4'd1;

    // One input beat.
    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              end_of_string;
    } byte_beat_t;

    // One result beat.
    typedef struct packed {
        logic [POS_OUT_W-1:0] piece_start;
        logic [POS_OUT_W-1:0] piece_end;
        logic                 last_piece;
    } piece_beat_t;

    // Control that every cell of the window chain receives.
    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctrl_t;

endpackage

/* rtl/core/byte_stream_delimiter_splitter.sv */
// Byte stream delimiter splitter: top level with the window cell chain, the
// piece tracking and the output buffer. Depends on bsds_pkg, bsds_cell, bsds_skid.
// Throughput: one byte beat per cycle unless stalled; cells compare the window in parallel.
// A result beat is registered in the output buffer before it is offered.
// The output buffer holds two results, so input stalls only when both are waiting.
// Reset (rst_n low, asynchronous) clears the window, counters and buffer; delimiter is a comma.
module byte_stream_delimiter_splitter
#(
    parameter int               MAX_DELIMITER_BYTES = 8,
    parameter longint unsigned  MAX_STRING_LENGTH   = 65536
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              byte_valid,
    output logic                              byte_ready,
    input  bsds_pkg::byte_beat_t              byte_data,
    output logic                              piece_valid,
    input  logic                              piece_ready,
    output bsds_pkg::piece_beat_t             piece_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bsds_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bsds_pkg::DELIM_W-1:0]      cfg_data
);

    localparam int POS_W = $clog2(MAX_STRING_LENGTH + 1);
    localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_STRING_LENGTH);
    localparam logic [bsds_pkg::DLEN_W-1:0] MAX_DL = bsds_pkg::DLEN_W'(MAX_DELIMITER_BYTES);

    // Configuration registers; the length is stored already clamped.
    logic [bsds_pkg::DELIM_W-1:0] delim_reg;
    logic [bsds_pkg::DLEN_W-1:0]  dl_reg;
    logic [bsds_pkg::DLEN_W-1:0]  dl_written;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        dl_written = cfg_data[bsds_pkg::DLEN_W-1:0];
        if (dl_written == '0)
        begin
            dl_written = bsds_pkg::DLEN_W'(1);
        end
        else if (dl_written > MAX_DL)
        begin
            dl_written = MAX_DL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delim_reg <= bsds_pkg::DELIM_BYTES_RST;
            dl_reg    <= bsds_pkg::DELIM_LENGTH_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                bsds_pkg::REG_DELIM_BYTES:  delim_reg <= cfg_data;
                bsds_pkg::REG_DELIM_LENGTH: dl_reg    <= dl_written;
                default: ;
            endcase
        end
    end

    // Handshake and per-beat control.
    logic                 buf_space;
    logic                 byte_fire;
    bsds_pkg::cell_ctrl_t cell_ctrl;

    assign byte_ready      = buf_space;
    assign byte_fire       = byte_valid && byte_ready;
    assign cell_ctrl.shift = byte_fire;
    assign cell_ctrl.clear = byte_data.end_of_string;

    // Chain of window cells, newest byte in cell zero.
    logic [bsds_pkg::BYTE_W-1:0] chain [MAX_DELIMITER_BYTES+1];
    logic [MAX_DELIMITER_BYTES-1:0] hits;

    assign chain[0] = byte_data.data_byte;

    for (genvar j = 0; j < MAX_DELIMITER_BYTES; j++)
    begin : g_cell
        logic [bsds_pkg::DLEN_W-1:0] want_idx;
        logic [bsds_pkg::BYTE_W-1:0] want;
        logic                        enable;

        // Cell j sees delimiter byte dl-1-j once the window is aligned.
        assign want_idx = dl_reg - bsds_pkg::DLEN_W'(1) - bsds_pkg::DLEN_W'(j);
        assign want     = delim_reg[want_idx[2:0]*bsds_pkg::BYTE_W +: bsds_pkg::BYTE_W];
        assign enable   = bsds_pkg::DLEN_W'(j) < dl_reg;

        bsds_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (cell_ctrl),
            .byte_in  (chain[j]),
            .want     (want),
            .enable   (enable),
            .byte_out (chain[j+1]),
            .hit      (hits[j])
        );
    end

    // Piece tracking state.
    logic [POS_W-1:0]              pos_reg;
    logic [POS_W-1:0]              pos_next;
    logic [POS_W-1:0]              start_reg;
    logic [POS_W-1:0]              start_next;
    logic [bsds_pkg::DLEN_W-1:0]   bip_reg;
    logic [bsds_pkg::DLEN_W-1:0]   bip_next;
    logic [bsds_pkg::DLEN_W-1:0]   bip_inc;
    logic [POS_W-1:0]              pos_inc;
    logic [POS_W-1:0]              dl_wide;
    logic [POS_W-1:0]              delim_at;
    logic                          match;
    logic                          push;
    logic [POS_W-1:0]              res_start;
    logic [POS_W-1:0]              res_end;
    logic [POS_W+bsds_pkg::POS_OUT_W-1:0] start_ext;
    logic [POS_W+bsds_pkg::POS_OUT_W-1:0] end_ext;
    bsds_pkg::piece_beat_t         push_data;

    assign bip_inc = (bip_reg < MAX_DL) ? bip_reg + bsds_pkg::DLEN_W'(1) : bip_reg;
    assign pos_inc = (pos_reg < POS_LIMIT) ? pos_reg + POS_W'(1) : POS_LIMIT;
    assign dl_wide = POS_W'(dl_reg);
    assign match   = (bip_inc >= dl_reg) && (&hits);

    // Start of the delimiter, never before the piece start.
    always_comb
    begin
        delim_at = (pos_inc >= dl_wide) ? pos_inc - dl_wide : '0;
        if (delim_at < start_reg)
        begin
            delim_at = start_reg;
        end
    end

    // Decide the result of this beat and the next piece state.
    always_comb
    begin
        pos_next   = pos_reg;
        start_next = start_reg;
        bip_next   = bip_reg;
        push       = 1'b0;
        res_start  = start_reg;
        res_end    = pos_inc;
        if (byte_fire)
        begin
            pos_next = pos_inc;
            bip_next = bip_inc;
            if (match)
            begin
                push       = 1'b1;
                res_end    = delim_at;
                start_next = pos_inc;
                bip_next   = '0;
            end
            else if (byte_data.end_of_string)
            begin
                push = 1'b1;
            end
            if (byte_data.end_of_string)
            begin
                pos_next   = '0;
                start_next = '0;
                bip_next   = '0;
            end
        end
    end

    assign start_ext              = {{bsds_pkg::POS_OUT_W{1'b0}}, res_start};
    assign end_ext                = {{bsds_pkg::POS_OUT_W{1'b0}}, res_end};
    assign push_data.piece_start  = start_ext[bsds_pkg::POS_OUT_W-1:0];
    assign push_data.piece_end    = end_ext[bsds_pkg::POS_OUT_W-1:0];
    assign push_data.last_piece   = byte_data.end_of_string;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            start_reg <= '0;
            bip_reg   <= '0;
        end
        else
        begin
            pos_reg   <= pos_next;
            start_reg <= start_next;
            bip_reg   <= bip_next;
        end
    end

    // Output buffer.
    bsds_skid u_skid
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .push_data   (push_data),
        .space       (buf_space),
        .piece_valid (piece_valid),
        .piece_ready (piece_ready),
        .piece_data  (piece_data)
    );

    // The piece start never runs ahead of the byte position.
    a_start_le_pos: assert property (@(posedge clk) disable iff (!rst_n)
        start_reg <= pos_reg)
        else $error("piece start beyond byte position");

    // The byte count of a piece stays within the window.
    a_bip_range: assert property (@(posedge clk) disable iff (!rst_n)
        bip_reg <= MAX_DL)
        else $error("piece byte count beyond window length");

    // The last byte of a string always yields a result and restarts counting.
    a_eos_result: assert property (@(posedge clk) disable iff (!rst_n)
        (byte_fire && byte_data.end_of_string) |=> (piece_valid && pos_reg == '0))
        else $error("end of string without a final piece");

endmodule

/* rtl/core/bsds_cell.sv */
// One cell of the byte window chain: holds one recent byte and compares the
// byte shifting into it against its delimiter byte. Depends on bsds_pkg.
module bsds_cell
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  bsds_pkg::cell_ctrl_t         ctrl,
    input  logic [bsds_pkg::BYTE_W-1:0]  byte_in,
    input  logic [bsds_pkg::BYTE_W-1:0]  want,
    input  logic                         enable,
    output logic [bsds_pkg::BYTE_W-1:0]  byte_out,
    output logic                         hit
);

    logic [bsds_pkg::BYTE_W-1:0] byte_reg;
    logic [bsds_pkg::BYTE_W-1:0] byte_next;

    // A cell beyond the delimiter length never blocks a match.
    assign hit = !enable || (byte_in == want);

    // Shift in the neighbour's byte, or clear at the end of a string.
    always_comb
    begin
        byte_next = byte_reg;
        if (ctrl.shift)
        begin
            byte_next = ctrl.clear ? '0 : byte_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg <= '0;
        end
        else
        begin
            byte_reg <= byte_next;
        end
    end

    assign byte_out = byte_reg;

endmodule

/* rtl/core/bsds_skid.sv */
// Two-entry output buffer for result beats, so that input beats keep flowing
// while a result waits to be taken. Depends on bsds_pkg.
module bsds_skid
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  bsds_pkg::piece_beat_t push_data,
    output logic                  space,
    output logic                  piece_valid,
    input  logic                  piece_ready,
    output bsds_pkg::piece_beat_t piece_data
);

    logic                  out_valid_reg;
    logic                  out_valid_next;
    bsds_pkg::piece_beat_t out_data_reg;
    bsds_pkg::piece_beat_t out_data_next;
    logic                  skid_valid_reg;
    logic                  skid_valid_next;
    bsds_pkg::piece_beat_t skid_data_reg;
    bsds_pkg::piece_beat_t skid_data_next;

    // A push is only offered while the skid entry is free.
    assign space = !skid_valid_reg;

    // Move beats between the skid entry and the output register.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || piece_ready)
        begin
            if (skid_valid_reg)
            begin
                out_data_next   = skid_data_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else if (push)
            begin
                out_data_next  = push_data;
                out_valid_next = 1'b1;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            skid_data_next  = push_data;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign piece_valid = out_valid_reg;
    assign piece_data  = out_data_reg;

    // The skid entry only fills behind a waiting output beat.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry holds a beat while the output is empty");

    // A stalled output beat is not overwritten.
    a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !piece_ready) |=> (out_valid_reg && $stable(out_data_reg)))
        else $error("stalled result beat changed");

endmodule
